// File: rtl/ewh_pkg.sv
// ----------------------------------------------------------------------------
// ewh_pkg
// Shared types and constants of the equi-width histogram binner.
// ----------------------------------------------------------------------------
package ewh_pkg;

    localparam int MAX_BUCKETS = 64;
    localparam int COUNT_WIDTH = 32;
    localparam int IDX_W       = $clog2(MAX_BUCKETS);
    localparam int NB_W        = 7;
    localparam int VAL_W       = 64;
    // d*B and k*span need 64 + NB_W bits
    localparam int PROD_W      = VAL_W + NB_W;

    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_MERGE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    localparam logic [1:0] CFG_MIN = 2'd0;
    localparam logic [1:0] CFG_MAX = 2'd1;
    localparam logic [1:0] CFG_NB  = 2'd2;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // data moved from one search cell to the next
    typedef struct packed {
        logic              vld;
        logic [PROD_W-1:0] acc;   // k*span so far
        logic [PROD_W-1:0] tgt;   // d*B
        logic [IDX_W-1:0]  k;
        logic              done;
    } t_link;

endpackage

// File: rtl/equi_width_histogram_binner.sv
// ----------------------------------------------------------------------------
// equi_width_histogram_binner
// Equi-width histogram: bins samples, merges, reads and clears bucket counts.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive i_mode and payload with start high; the item is
//   taken when start is high and busy is low. busy stays high until the
//   cycle in which the item's result is strobed.
//   Config channel: i_cfg_valid/o_cfg_ready with index and data; ready only
//   while idle. Index 0 range_min, 1 range_max, 2 bucket_count.
//   Result: one item per command, on o_* with o_done high for one cycle.
// Timing:
//   Mode 0 runs the sample through a chain of MAX_BUCKETS-1 search cells,
//   one compare-add per cell and cycle, after a multiply front end
//   (product, then chain launch), then one memory read and one write;
//   busy stays high from the accepting edge through the write.
//   Modes 1-3 skip the chain and go from the front end to the read and write.
//   The result strobe follows in the cycle after the write, busy already low,
//   so the next item can be taken at the edge that ends it; no new item is
//   taken while one is in flight. The search chain length sets the sample time.
// Reset: filled flags and the filled total clear at once; counts stay
//   undefined and are zeroed when a bucket is first touched. No sweep.
//   The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module equi_width_histogram_binner import ewh_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             i_mode,
    input  logic signed [VAL_W-1:0] i_sample_value,
    input  logic [IDX_W-1:0]       i_bucket_select,
    input  logic [31:0]            i_merge_count,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [1:0]             i_cfg_index,
    input  logic [VAL_W-1:0]       i_cfg_data,
    output logic                   o_done,
    output logic [IDX_W-1:0]       o_bucket_index,
    output logic [COUNT_WIDTH-1:0] o_bucket_total,
    output logic                   o_bucket_filled,
    output logic                   o_out_of_range,
    output logic                   o_saturated
);
    localparam int NCELL = MAX_BUCKETS - 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_SRCH = 5'b00100,
        S_RD   = 5'b01000,
        S_WR   = 5'b10000
    } t_state;

    t_state r_state;

    // config
    logic signed [VAL_W-1:0] r_min, r_max;
    logic [NB_W-1:0]         r_nbreg;
    logic [NB_W-1:0]         w_nb;

    always_comb begin
        if (r_nbreg == '0) w_nb = NB_W'(1);
        else if (r_nbreg > NB_W'(MAX_BUCKETS)) w_nb = NB_W'(MAX_BUCKETS);
        else w_nb = r_nbreg;
    end

    assign o_cfg_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min   <= '0;
            r_max   <= 64'sd1024;
            r_nbreg <= NB_W'(64);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MIN: r_min   <= i_cfg_data;
                CFG_MAX: r_max   <= i_cfg_data;
                CFG_NB:  r_nbreg <= i_cfg_data[NB_W-1:0];
                default: ;
            endcase
        end
    end

    // item latch
    logic [1:0]             r_mode;
    logic [IDX_W-1:0]       r_sel;
    logic [31:0]            r_mc;
    logic                   r_oor;
    logic [VAL_W-1:0]       r_d, r_span;
    logic [PROD_W-1:0]      r_tgt;
    logic [IDX_W-1:0]       r_idx;
    logic [6:0]             r_cnt;

    // search chain
    t_link w_chain [NCELL+1];
    logic [PROD_W-1:0] w_span_ext;
    logic              w_launch;
    assign w_span_ext = PROD_W'(r_span);
    assign w_launch   = (r_state == S_MUL) && (r_cnt == 7'd1) && !r_oor &&
                        (r_mode == MODE_ADD);

    assign w_chain[0] = '{vld: w_launch, acc: '0, tgt: r_tgt, k: '0, done: 1'b0};

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        ewh_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_span (w_span_ext),
            .i_nb   (w_nb),
            .i_link (w_chain[g]),
            .o_link (w_chain[g+1])
        );
    end

    // count memory and flags
    logic [COUNT_WIDTH-1:0] r_mem [MAX_BUCKETS];
    logic [COUNT_WIDTH-1:0] r_rd;
    logic [MAX_BUCKETS-1:0] r_filled;
    logic [NB_W-1:0]        r_ftotal;
    logic                   r_was;
    logic                   r_done_q;
    logic [COUNT_WIDTH-1:0] w_old, w_add, w_new;
    logic                   w_inuse;

    assign w_inuse = {1'b0, r_sel} < w_nb;
    assign w_old   = r_was ? r_rd : '0;
    assign w_add   = (r_mode == MODE_ADD) ? COUNT_WIDTH'(1) : COUNT_WIDTH'(r_mc);
    assign w_new   = (w_add > COUNT_MAX - w_old) ? COUNT_MAX : w_old + w_add;

    always_ff @(posedge i_clk) begin
        if (r_state == S_RD) r_rd <= r_mem[r_idx];
        if (r_state == S_WR && (r_mode == MODE_MERGE ? w_inuse :
                                (r_mode == MODE_ADD && !r_oor)))
            r_mem[r_idx] <= w_new;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_filled <= '0;
            r_ftotal <= '0;
            r_done_q <= 1'b0;
        end else begin
            r_done_q <= (r_state == S_WR);
            unique case (r_state)
                S_IDLE: if (start) begin
                    r_state <= S_MUL;
                    r_cnt   <= '0;
                end
                S_MUL: begin
                    if (r_cnt == 7'd1) begin
                        if (r_mode == MODE_ADD && !r_oor) begin
                            r_state <= S_SRCH;
                            r_cnt   <= '0;
                        end else begin
                            r_idx   <= r_sel;
                            r_state <= S_RD;
                        end
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                S_SRCH: begin
                    r_cnt <= r_cnt + 7'd1;
                    if (w_chain[NCELL].vld) begin
                        r_idx   <= w_chain[NCELL].k;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_was   <= r_filled[r_idx];
                    r_state <= S_WR;
                end
                S_WR: begin
                    r_state <= S_IDLE;
                    if (r_mode == MODE_CLEAR) begin
                        r_filled <= '0;
                        r_ftotal <= '0;
                    end else if ((r_mode == MODE_ADD && !r_oor) ||
                                 (r_mode == MODE_MERGE && w_inuse)) begin
                        r_filled[r_idx] <= 1'b1;
                        if (!r_was) r_ftotal <= r_ftotal + NB_W'(1);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // front end: range check, then d*B (64x7)
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_mode <= i_mode;
            r_sel  <= i_bucket_select;
            r_mc   <= i_merge_count;
            r_oor  <= (r_max <= r_min) || (i_sample_value < r_min) ||
                      (i_sample_value >= r_max);
            r_d    <= i_sample_value - r_min;
            r_span <= r_max - r_min;
        end
        if (r_state == S_MUL && r_cnt == 7'd0)
            r_tgt <= PROD_W'(r_d) * PROD_W'(w_nb);
    end

    // result
    logic [IDX_W-1:0]       n_index;
    logic [COUNT_WIDTH-1:0] n_total;
    logic                   n_filled, n_oor, n_sat;

    always_comb begin
        n_index  = '0;
        n_total  = '0;
        n_filled = 1'b0;
        n_oor    = 1'b0;
        n_sat    = 1'b0;
        unique case (r_mode)
            MODE_ADD: begin
                if (r_oor) n_oor = 1'b1;
                else begin
                    n_index  = r_idx;
                    n_total  = w_new;
                    n_filled = 1'b1;
                    n_sat    = (w_new == COUNT_MAX);
                end
            end
            MODE_MERGE: begin
                n_index = r_sel;
                if (w_inuse) begin
                    n_total  = w_new;
                    n_filled = 1'b1;
                    n_sat    = (w_new == COUNT_MAX);
                end
            end
            MODE_READ: begin
                n_index = r_sel;
                if (w_inuse && r_was) begin
                    n_total  = r_rd;
                    n_filled = 1'b1;
                    n_sat    = (r_rd == COUNT_MAX);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WR) begin
            o_bucket_index  <= n_index;
            o_bucket_total  <= n_total;
            o_bucket_filled <= n_filled;
            o_out_of_range  <= n_oor;
            o_saturated     <= n_sat;
        end
    end
    assign o_done  = r_done_q;
    assign busy    = (r_state != S_IDLE);

    // filled total always equals the count of set flags
    a_ftotal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ftotal == NB_W'($countones(r_filled)))
        else $error("filled total mismatch");
    a_done_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");
    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result while busy");
endmodule

// File: rtl/ewh_cell.sv
// ----------------------------------------------------------------------------
// ewh_cell
// One bucket-search step: tries k+1, hands the result to the next cell.
// ----------------------------------------------------------------------------
module ewh_cell import ewh_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [PROD_W-1:0] i_span,
    input  logic [NB_W-1:0]   i_nb,
    input  t_link             i_link,
    output t_link             o_link
);
    t_link r_link, n_link;
    logic [PROD_W-1:0] w_next;
    logic [NB_W-1:0]   w_k1;

    always_comb begin
        w_next = i_link.acc + i_span;
        w_k1   = NB_W'(i_link.k) + NB_W'(1);
        n_link = i_link;
        if (!i_link.done) begin
            if (w_k1 < i_nb && w_next <= i_link.tgt) begin
                n_link.acc = w_next;
                n_link.k   = i_link.k + IDX_W'(1);
            end else begin
                n_link.done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link.vld <= 1'b0;
        end else begin
            r_link.vld <= n_link.vld;
        end
        r_link.acc  <= n_link.acc;
        r_link.tgt  <= n_link.tgt;
        r_link.k    <= n_link.k;
        r_link.done <= n_link.done;
    end

    assign o_link = r_link;
endmodule
